// ===== hdl/tss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    // default sizes
    localparam int MAX_ROWS_DEF  = 8;
    localparam int MAX_VARS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    // register indexes
    localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] REG_NUM_VARS  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_MAX_PIV   = 2'd3;

    // register reset values
    localparam logic [3:0]  NUM_ROWS_RST  = 4'd8;
    localparam logic [3:0]  NUM_VARS_RST  = 4'd8;
    localparam logic [15:0] THRESHOLD_RST = 16'd66;
    localparam logic [15:0] MAX_PIV_RST   = 16'd1024;

    // input actions
    localparam logic [1:0] ACT_LOAD_TAB  = 2'd0;
    localparam logic [1:0] ACT_LOAD_COST = 2'd1;
    localparam logic [1:0] ACT_SOLVE     = 2'd2;

    // solve status codes
    localparam logic [2:0] ST_OPTIMAL    = 3'd0;
    localparam logic [2:0] ST_ART_ZERO   = 3'd1;
    localparam logic [2:0] ST_INFEASIBLE = 3'd2;
    localparam logic [2:0] ST_UNBOUNDED  = 3'd3;
    localparam logic [2:0] ST_PIV_LIMIT  = 3'd4;

    // record kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BASIS  = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        sx64 = {{32{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tss_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// (a * 2^frac) / b, truncated toward zero, saturated; one quotient bit per cycle
module tss_div
    import tss_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [31:0]      q
);

    localparam int DW  = 32 + FRAC_BITS;
    localparam int NCW = $clog2(DW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [NCW-1:0]    cnt_reg;
    logic [DW-1:0]     qsh_reg;
    logic [32:0]       rem_reg;
    logic [31:0]       bmag_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [31:0]       amag;
    logic [32:0]       rem_shift;
    logic signed [63:0] mag64;

    assign amag      = a[31] ? (~a + 32'd1) : a;
    assign rem_shift = {rem_reg[31:0], qsh_reg[DW-1]};
    assign mag64     = {{(64 - DW){1'b0}}, qsh_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + NCW'(1);
                if (cnt_reg == NCW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qsh_reg  <= {amag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            bmag_reg <= b[31] ? (~b + 32'd1) : b;
            neg_reg  <= a[31] ^ b[31];
            zero_reg <= (b == 32'sd0);
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, bmag_reg})
            begin
                rem_reg <= rem_shift - {1'b0, bmag_reg};
                qsh_reg <= {qsh_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                qsh_reg <= {qsh_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign q    = zero_reg ? 32'sd0 : sat32(neg_reg ? -mag64 : mag64);

endmodule

`default_nettype wire

// ===== hdl/tableau_simplex_solver.sv =====
// dense tableau simplex, big-M start basis, largest reduced cost enters
// load items are taken whenever the solver is idle; a solve item holds the input side until its last record
// solve: init of the start basis, then per pivot pricing, a ratio test, row normalize and
// eliminate, with divider width DW = 32+FRAC_BITS
// (one-bit-per-cycle divider, single-port tableau memory); then the objective, m+1 records
// rst_n clears control and registers to defaults; tableau and cost memories hold until written
`timescale 1ns / 1ps
`default_nettype none

module tableau_simplex_solver
    import tss_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_VARS  = MAX_VARS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row_index[2:0], column_index[8:3], entry_value[40:9]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // solve_status[2:0], objective_value[34:3],
                                        // basis_row[37:35], basic_column[42:38],
                                        // basic_value[74:43]
    output logic [0:0]       m_tuser,   // record_kind[0]
    output logic             m_tlast    // last_record
);

    localparam int MAX_COLS = 2 * MAX_VARS + 2 * MAX_ROWS;
    localparam int STRIDE   = MAX_COLS + 1;
    localparam int DEPTH    = MAX_ROWS * STRIDE;
    localparam int AW       = $clog2(DEPTH);
    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MW       = $clog2(MAX_ROWS + 1);
    localparam int NW       = $clog2(MAX_VARS + 1);
    localparam int CW       = $clog2(MAX_COLS + 1);
    localparam int CCW      = $clog2(MAX_COLS);
    localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

    // sequencer states
    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_INIT_RD  = 6'd1;
    localparam logic [5:0] S_INIT_CHK = 6'd2;
    localparam logic [5:0] S_INIT_CB  = 6'd3;
    localparam logic [5:0] S_PR_START = 6'd4;
    localparam logic [5:0] S_PR_COL   = 6'd5;
    localparam logic [5:0] S_PR_CJ    = 6'd6;
    localparam logic [5:0] S_PR_MUL   = 6'd7;
    localparam logic [5:0] S_PR_ACC   = 6'd8;
    localparam logic [5:0] S_PR_RC    = 6'd9;
    localparam logic [5:0] S_PR_DONE  = 6'd10;
    localparam logic [5:0] S_RT_RD    = 6'd11;
    localparam logic [5:0] S_RT_E     = 6'd12;
    localparam logic [5:0] S_RT_R     = 6'd13;
    localparam logic [5:0] S_RT_DIV   = 6'd14;
    localparam logic [5:0] S_RT_DONE  = 6'd15;
    localparam logic [5:0] S_PV_CB    = 6'd16;
    localparam logic [5:0] S_NM_RD    = 6'd17;
    localparam logic [5:0] S_NM_GO    = 6'd18;
    localparam logic [5:0] S_NM_WAIT  = 6'd19;
    localparam logic [5:0] S_EL_ROW   = 6'd20;
    localparam logic [5:0] S_EL_LAT   = 6'd21;
    localparam logic [5:0] S_EL_RDP   = 6'd22;
    localparam logic [5:0] S_EL_RDI   = 6'd23;
    localparam logic [5:0] S_EL_MUL   = 6'd24;
    localparam logic [5:0] S_EL_WR    = 6'd25;
    localparam logic [5:0] S_OB_START = 6'd26;
    localparam logic [5:0] S_OB_RD    = 6'd27;
    localparam logic [5:0] S_OB_MUL   = 6'd28;
    localparam logic [5:0] S_OB_ACC   = 6'd29;
    localparam logic [5:0] S_OUT_ST   = 6'd30;
    localparam logic [5:0] S_OUT_RD   = 6'd31;
    localparam logic [5:0] S_OUT_LD   = 6'd32;

    // configuration registers
    logic [3:0]  num_rows_reg;
    logic [3:0]  num_vars_reg;
    logic [15:0] thresh_reg;
    logic [15:0] max_piv_reg;

    // input item fields
    logic [1:0]         in_action;
    logic [2:0]         in_row;
    logic [5:0]         in_col;
    logic signed [31:0] in_value;

    assign in_action = s_tuser;
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[8:3];
    assign in_value  = s_tdata[40:9];

    // memories: tableau rows by stride, and the cost vector
    logic signed [31:0] tab_mem  [DEPTH];
    logic signed [31:0] cost_mem [MAX_COLS];
    logic signed [31:0] t_q;
    logic signed [31:0] c_q;

    logic               t_re, t_we, c_re, c_we;
    logic [RW-1:0]      t_row;
    logic [CW-1:0]      t_col;
    logic [AW-1:0]      t_addr;
    logic signed [31:0] t_wdata;
    logic [CCW-1:0]     c_addr;

    // solve state
    logic [5:0]         state_reg;
    logic [MW-1:0]      m_reg;
    logic [NW-1:0]      n_reg;
    logic [CW-1:0]      cols_reg;
    logic [CW-1:0]      basis_reg [MAX_ROWS];
    logic signed [31:0] cb_reg    [MAX_ROWS];
    logic [MAX_COLS-1:0] is_basic_reg;
    logic [15:0]        piv_cnt_reg;
    logic [RW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      enter_reg;
    logic signed [31:0] best_reg;
    logic               found_reg;
    logic [RW-1:0]      prow_reg;
    logic signed [31:0] pratio_reg;
    logic signed [31:0] pe_reg;
    logic               have_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] cj_reg;
    logic signed [31:0] mul_reg;
    logic signed [31:0] pv_reg;
    logic signed [31:0] tij_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] z_reg;
    logic [2:0]         status_reg;
    logic               chk_inf_reg;
    logic               infeas_reg;

    // output register
    logic               ov_reg;
    logic               o_kind_reg;
    logic [2:0]         o_status_reg;
    logic signed [31:0] o_obj_reg;
    logic [2:0]         o_row_reg;
    logic [4:0]         o_col_reg;
    logic signed [31:0] o_val_reg;
    logic               o_last_reg;

    // divider
    logic               div_start;
    logic signed [31:0] div_b;
    logic               div_done;
    logic signed [31:0] div_q;

    // helpers
    logic [MW-1:0]      m_c;
    logic [NW-1:0]      n_c;
    logic [CW-1:0]      art_lo, art_hi;
    logic [RW-1:0]      i_next;
    logic               last_row;
    logic [CW-1:0]      init_col;
    logic signed [31:0] qm;
    logic signed [31:0] rc;
    logic signed [31:0] elim_val;
    logic               art_any;
    logic               out_free;
    logic               o_load;
    logic               e_pos;
    logic [CW-1:0]      basis_i;

    function automatic logic [AW-1:0] taddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        taddr = AW'(32'(r) * STRIDE + 32'(c));
    endfunction

    // clamp row and variable counts to 1..max
    always_comb
    begin
        if (num_rows_reg == 4'd0)
            m_c = MW'(1);
        else if (32'(num_rows_reg) > MAX_ROWS)
            m_c = MW'(MAX_ROWS);
        else
            m_c = MW'(num_rows_reg);
        if (num_vars_reg == 4'd0)
            n_c = NW'(1);
        else if (32'(num_vars_reg) > MAX_VARS)
            n_c = NW'(MAX_VARS);
        else
            n_c = NW'(num_vars_reg);
    end

    assign art_lo   = CW'(n_reg) + CW'(m_reg);
    assign art_hi   = CW'(n_reg) + CW'(m_reg) + CW'(m_reg);
    assign i_next   = i_reg + RW'(1);
    assign last_row = (MW'(i_reg) + MW'(1)) == m_reg;
    assign basis_i  = basis_reg[i_reg];
    // start basis: artificial column when the slack entry is -1
    assign init_col = (t_q == NEG_ONE) ? (art_lo + CW'(i_reg)) : (CW'(n_reg) + CW'(i_reg));
    // product shifted down with floor rounding, saturated
    assign qm       = sat32(prod_reg >>> FRAC_BITS);
    assign rc       = sat32(sx64(cj_reg) - sx64(sat32(z_reg)));
    assign elim_val = sat32(sx64(tij_reg) - sx64(qm));
    assign out_free = !ov_reg || m_tready;
    // a record is loaded into the output register this cycle
    assign o_load   = ((state_reg == S_OUT_ST) || (state_reg == S_OUT_LD)) && out_free;
    assign e_pos    = !e_reg[31] && (e_reg != 32'sd0);

    always_comb
    begin
        art_any = 1'b0;
        for (int k = 0; k < MAX_ROWS; k++)
        begin
            if ((32'(k) < 32'(m_reg)) && (basis_reg[k] >= art_lo) && (basis_reg[k] < art_hi))
                art_any = 1'b1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // memory port control per state
    always_comb
    begin
        t_re    = 1'b0;
        t_we    = 1'b0;
        t_row   = i_reg;
        t_col   = j_reg;
        t_wdata = in_value;
        c_re    = 1'b0;
        c_we    = 1'b0;
        c_addr  = CCW'(j_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && in_action == ACT_LOAD_TAB &&
                    32'(in_row) < MAX_ROWS && 32'(in_col) <= MAX_COLS)
                begin
                    t_we  = 1'b1;
                    t_row = RW'(in_row);
                    t_col = CW'(in_col);
                end
                if (s_tvalid && in_action == ACT_LOAD_COST && 32'(in_col) < MAX_COLS)
                begin
                    c_we   = 1'b1;
                    c_addr = CCW'(in_col);
                end
            end
            S_INIT_RD:
            begin
                t_re  = 1'b1;
                t_col = CW'(n_reg) + CW'(i_reg);
            end
            S_INIT_CHK:
            begin
                c_re   = 1'b1;
                c_addr = CCW'(init_col);
            end
            S_PR_COL:
                c_re = (j_reg != cols_reg) && !is_basic_reg[CCW'(j_reg)];
            S_PR_CJ:
            begin
                t_re  = 1'b1;
                t_row = '0;
            end
            S_PR_ACC:
            begin
                t_re  = !last_row;
                t_row = i_next;
            end
            S_RT_RD, S_EL_ROW:
            begin
                t_re  = (state_reg == S_RT_RD) || (i_reg != prow_reg);
                t_col = enter_reg;
            end
            S_RT_E, S_OB_RD, S_OUT_RD:
            begin
                t_re  = 1'b1;
                t_col = cols_reg;
            end
            S_RT_DONE:
            begin
                c_re   = have_reg && (piv_cnt_reg < max_piv_reg);
                c_addr = CCW'(enter_reg);
            end
            S_NM_RD, S_EL_RDP:
            begin
                t_re  = 1'b1;
                t_row = prow_reg;
            end
            S_NM_WAIT:
            begin
                t_we    = div_done;
                t_row   = prow_reg;
                t_wdata = div_q;
            end
            S_EL_RDI:
                t_re = 1'b1;
            S_EL_WR:
            begin
                t_we    = 1'b1;
                t_wdata = elim_val;
            end
            default:
            begin
                t_re = 1'b0;
            end
        endcase
    end

    assign t_addr = taddr(t_row, t_col);

    always_ff @(posedge clk)
    begin
        if (t_we)
            tab_mem[t_addr] <= t_wdata;
        if (t_re)
            t_q <= tab_mem[t_addr];
        if (c_we)
            cost_mem[c_addr] <= in_value;
        if (c_re)
            c_q <= cost_mem[c_addr];
    end

    assign div_start = ((state_reg == S_RT_R) && e_pos) || (state_reg == S_NM_GO);
    assign div_b     = (state_reg == S_NM_GO) ? pe_reg : e_reg;

    tss_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (t_q),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_RST;
            num_vars_reg <= NUM_VARS_RST;
            thresh_reg   <= THRESHOLD_RST;
            max_piv_reg  <= MAX_PIV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_ROWS:  num_rows_reg <= cfg_data[3:0];
                REG_NUM_VARS:  num_vars_reg <= cfg_data[3:0];
                REG_THRESHOLD: thresh_reg   <= cfg_data;
                REG_MAX_PIV:   max_piv_reg  <= cfg_data;
                default:       thresh_reg   <= thresh_reg;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_reg       <= 1'b0;
            is_basic_reg <= '0;
            piv_cnt_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
            infeas_reg   <= 1'b0;
            chk_inf_reg  <= 1'b0;
            status_reg   <= ST_OPTIMAL;
            for (int k = 0; k < MAX_ROWS; k++)
                basis_reg[k] <= '0;
        end
        else
        begin
            if (o_load)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && in_action == ACT_SOLVE)
                    begin
                        m_reg        <= m_c;
                        n_reg        <= n_c;
                        cols_reg     <= CW'(2 * 32'(n_c) + 2 * 32'(m_c));
                        is_basic_reg <= '0;
                        piv_cnt_reg  <= '0;
                        i_reg        <= '0;
                        state_reg    <= S_INIT_RD;
                    end
                end
                S_INIT_RD:
                    state_reg <= S_INIT_CHK;
                S_INIT_CHK:
                begin
                    basis_reg[i_reg]               <= init_col;
                    is_basic_reg[CCW'(init_col)]   <= 1'b1;
                    state_reg                      <= S_INIT_CB;
                end
                S_INIT_CB:
                begin
                    cb_reg[i_reg] <= c_q;
                    i_reg         <= i_next;
                    state_reg     <= last_row ? S_PR_START : S_INIT_RD;
                end
                S_PR_START:
                begin
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_PR_COL;
                end
                S_PR_COL:
                begin
                    if (j_reg == cols_reg)
                        state_reg <= S_PR_DONE;
                    else if (is_basic_reg[CCW'(j_reg)])
                        j_reg <= j_reg + CW'(1);
                    else
                    begin
                        i_reg     <= '0;
                        z_reg     <= '0;
                        state_reg <= S_PR_CJ;
                    end
                end
                S_PR_CJ:
                begin
                    cj_reg    <= c_q;
                    state_reg <= S_PR_MUL;
                end
                S_PR_MUL:
                begin
                    prod_reg  <= cb_reg[i_reg] * t_q;
                    state_reg <= S_PR_ACC;
                end
                S_PR_ACC:
                begin
                    z_reg <= z_reg + sx64(qm);
                    if (last_row)
                        state_reg <= S_PR_RC;
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_PR_MUL;
                    end
                end
                S_PR_RC:
                begin
                    // strictly larger wins, so the lowest index keeps ties
                    if (rc > $signed({16'd0, thresh_reg}) && (!found_reg || rc > best_reg))
                    begin
                        found_reg <= 1'b1;
                        enter_reg <= j_reg;
                        best_reg  <= rc;
                    end
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= S_PR_COL;
                end
                S_PR_DONE:
                begin
                    if (found_reg)
                    begin
                        i_reg     <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= S_RT_RD;
                    end
                    else
                    begin
                        status_reg  <= art_any ? ST_ART_ZERO : ST_OPTIMAL;
                        chk_inf_reg <= art_any;
                        state_reg   <= S_OB_START;
                    end
                end
                S_RT_RD:
                    state_reg <= S_RT_E;
                S_RT_E:
                begin
                    e_reg     <= t_q;
                    state_reg <= S_RT_R;
                end
                S_RT_R:
                begin
                    // entries at or below zero are skipped
                    if (e_pos)
                        state_reg <= S_RT_DIV;
                    else if (last_row)
                        state_reg <= S_RT_DONE;
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_RT_RD;
                    end
                end
                S_RT_DIV:
                begin
                    if (div_done)
                    begin
                        if (!have_reg || div_q < pratio_reg)
                        begin
                            have_reg   <= 1'b1;
                            prow_reg   <= i_reg;
                            pratio_reg <= div_q;
                            pe_reg     <= e_reg;
                        end
                        if (last_row)
                            state_reg <= S_RT_DONE;
                        else
                        begin
                            i_reg     <= i_next;
                            state_reg <= S_RT_RD;
                        end
                    end
                end
                S_RT_DONE:
                begin
                    if (!have_reg)
                    begin
                        status_reg  <= ST_UNBOUNDED;
                        chk_inf_reg <= 1'b0;
                        state_reg   <= S_OB_START;
                    end
                    else if (piv_cnt_reg >= max_piv_reg)
                    begin
                        status_reg  <= ST_PIV_LIMIT;
                        chk_inf_reg <= 1'b0;
                        state_reg   <= S_OB_START;
                    end
                    else
                    begin
                        piv_cnt_reg <= piv_cnt_reg + 16'd1;
                        // leaving column drops out, entering column comes in
                        is_basic_reg <= (is_basic_reg &
                                         ~(MAX_COLS'(1) << CCW'(basis_reg[prow_reg]))) |
                                        (MAX_COLS'(1) << CCW'(enter_reg));
                        basis_reg[prow_reg] <= enter_reg;
                        state_reg           <= S_PV_CB;
                    end
                end
                S_PV_CB:
                begin
                    cb_reg[prow_reg] <= c_q;
                    j_reg            <= '0;
                    state_reg        <= S_NM_RD;
                end
                S_NM_RD:
                    state_reg <= S_NM_GO;
                S_NM_GO:
                    state_reg <= S_NM_WAIT;
                S_NM_WAIT:
                begin
                    if (div_done)
                    begin
                        if (j_reg == cols_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_EL_ROW;
                        end
                        else
                        begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= S_NM_RD;
                        end
                    end
                end
                S_EL_ROW:
                begin
                    if (i_reg == prow_reg)
                    begin
                        if (last_row)
                            state_reg <= S_PR_START;
                        else
                            i_reg <= i_next;
                    end
                    else
                        state_reg <= S_EL_LAT;
                end
                S_EL_LAT:
                begin
                    mul_reg   <= t_q;
                    j_reg     <= '0;
                    state_reg <= S_EL_RDP;
                end
                S_EL_RDP:
                    state_reg <= S_EL_RDI;
                S_EL_RDI:
                begin
                    pv_reg    <= t_q;
                    state_reg <= S_EL_MUL;
                end
                S_EL_MUL:
                begin
                    tij_reg   <= t_q;
                    prod_reg  <= mul_reg * pv_reg;
                    state_reg <= S_EL_WR;
                end
                S_EL_WR:
                begin
                    if (j_reg != cols_reg)
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_EL_RDP;
                    end
                    else if (last_row)
                        state_reg <= S_PR_START;
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_EL_ROW;
                    end
                end
                S_OB_START:
                begin
                    i_reg      <= '0;
                    z_reg      <= '0;
                    infeas_reg <= 1'b0;
                    state_reg  <= S_OB_RD;
                end
                S_OB_RD:
                    state_reg <= S_OB_MUL;
                S_OB_MUL:
                begin
                    prod_reg <= cb_reg[i_reg] * t_q;
                    // artificial still basic with nonzero rhs
                    if (basis_i >= art_lo && basis_i < art_hi && t_q != 32'sd0)
                        infeas_reg <= 1'b1;
                    state_reg <= S_OB_ACC;
                end
                S_OB_ACC:
                begin
                    z_reg <= z_reg + sx64(qm);
                    if (last_row)
                        state_reg <= S_OUT_ST;
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_OB_RD;
                    end
                end
                S_OUT_ST:
                begin
                    if (out_free)
                    begin
                        o_kind_reg   <= KIND_STATUS;
                        o_status_reg <= (chk_inf_reg && infeas_reg) ? ST_INFEASIBLE : status_reg;
                        o_obj_reg    <= sat32(z_reg);
                        o_row_reg    <= '0;
                        o_col_reg    <= '0;
                        o_val_reg    <= '0;
                        o_last_reg   <= 1'b0;
                        i_reg        <= '0;
                        state_reg    <= S_OUT_RD;
                    end
                end
                S_OUT_RD:
                    state_reg <= S_OUT_LD;
                S_OUT_LD:
                begin
                    if (out_free)
                    begin
                        o_kind_reg   <= KIND_BASIS;
                        o_status_reg <= ST_OPTIMAL;
                        o_obj_reg    <= '0;
                        o_row_reg    <= 3'(i_reg);
                        o_col_reg    <= 5'(basis_i);
                        o_val_reg    <= t_q;
                        o_last_reg   <= last_row;
                        i_reg        <= i_next;
                        state_reg    <= last_row ? S_IDLE : S_OUT_RD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, o_val_reg, o_col_reg, o_row_reg, o_obj_reg, o_status_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

// ===== bench/tableau_simplex_solver_tb.sv =====
`timescale 1ns / 1ps

module tableau_simplex_solver_tb;
    import tss_pkg::*;

    // one output record as the solver should produce it
    typedef struct {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] objective;
        logic [2:0]  row;
        logic [4:0]  column;
        logic [31:0] value;
        logic        last;
    } solve_record_t;

    localparam int ONE_Q = 65536;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // row_index[2:0], column_index[8:3], entry_value[40:9]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // solve_status[2:0], objective_value[34:3], basis_row[37:35],
                            // basic_column[42:38], basic_value[74:43]
    logic [0:0]  m_tuser;   // record_kind[0]
    logic        m_tlast;

    tableau_simplex_solver DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // shadow of the solver contents and registers
    int          tab_shadow [8][33];
    int          cost_shadow [32];
    int          basis_shadow [8];
    logic [3:0]  rows_reg;
    logic [3:0]  vars_reg;
    logic [15:0] thresh_reg;
    logic [15:0] maxpiv_reg;

    solve_record_t pending_records[$];

    int  mismatch_count;
    int  items_sent;
    int  records_seen;
    int  solves_done;
    int  status_hist [5];
    bit  calm;          // no idling on either side while set

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous limit against a hung solver
    initial
    begin
        #30_000_000;
        $display("timeout with %0d records outstanding", pending_records.size());
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- arithmetic

    function automatic int sat_q(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    // product floored back to Q16.16
    function automatic int mul_q(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat_q(p >>> 16);
    endfunction

    // quotient truncated toward zero, zero divisor gives zero
    function automatic int div_q(int a, int b);
        if (b == 0)
            return 0;
        return sat_q((longint'(a) <<< 16) / longint'(b));
    endfunction

    function automatic int used_count(logic [3:0] v, int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // ---------------------------------------------------------------- solver shadow

    task automatic predict_solve();
        int  m, n, cols, i, j, c;
        int  enter, prow, status, pcount;
        int  rc, best, pratio, r, e, pdiv, mul;
        bit  art, have_enter, have_pivot;
        bit  is_basic [32];
        longint z, acc;
        solve_record_t rec;
        m = used_count(rows_reg, 8);
        n = used_count(vars_reg, 8);
        cols = 2 * n + 2 * m;
        status = 0;
        for (j = 0; j < 32; j++)
            is_basic[j] = 1'b0;
        // big-M start: artificial where the slack diagonal is minus one
        for (i = 0; i < m; i++)
        begin
            c = (tab_shadow[i][n + i] == -ONE_Q) ? n + m + i : n + i;
            basis_shadow[i] = c;
            is_basic[c] = 1'b1;
        end
        pcount = 0;
        while (1)
        begin
            art = 1'b0;
            have_enter = 1'b0;
            have_pivot = 1'b0;
            enter = 0;
            prow = 0;
            best = 0;
            pratio = 0;
            for (i = 0; i < m; i++)
                if (basis_shadow[i] >= n + m && basis_shadow[i] < n + 2 * m)
                    art = 1'b1;
            // pricing, lowest index wins ties
            for (j = 0; j < cols; j++)
            begin
                if (is_basic[j])
                    continue;
                z = 0;
                for (i = 0; i < m; i++)
                    z += mul_q(cost_shadow[basis_shadow[i] % 32], tab_shadow[i][j]);
                rc = sat_q(longint'(cost_shadow[j]) - longint'(sat_q(z)));
                if (rc > int'(thresh_reg) && (!have_enter || rc > best))
                begin
                    have_enter = 1'b1;
                    enter = j;
                    best = rc;
                end
            end
            if (!have_enter)
            begin
                status = ST_OPTIMAL;
                if (art)
                begin
                    status = ST_ART_ZERO;
                    for (i = 0; i < m; i++)
                        if (basis_shadow[i] >= n + m && basis_shadow[i] < n + 2 * m &&
                            tab_shadow[i][cols] != 0)
                            status = ST_INFEASIBLE;
                end
                break;
            end
            // ratio test over positive entries
            for (i = 0; i < m; i++)
            begin
                e = tab_shadow[i][enter];
                if (e <= 0)
                    continue;
                r = div_q(tab_shadow[i][cols], e);
                if (!have_pivot || r < pratio)
                begin
                    have_pivot = 1'b1;
                    prow = i;
                    pratio = r;
                end
            end
            if (!have_pivot)
            begin
                status = ST_UNBOUNDED;
                break;
            end
            if (pcount >= int'(maxpiv_reg))
            begin
                status = ST_PIV_LIMIT;
                break;
            end
            pcount = (pcount + 1) & 16'hffff;
            is_basic[basis_shadow[prow] % 32] = 1'b0;
            basis_shadow[prow] = enter;
            is_basic[enter] = 1'b1;
            pdiv = tab_shadow[prow][enter];
            for (j = 0; j <= cols; j++)
                tab_shadow[prow][j] = div_q(tab_shadow[prow][j], pdiv);
            for (i = 0; i < m; i++)
            begin
                if (i == prow)
                    continue;
                mul = tab_shadow[i][enter];
                for (j = 0; j <= cols; j++)
                    tab_shadow[i][j] = sat_q(longint'(tab_shadow[i][j]) -
                                             longint'(mul_q(mul, tab_shadow[prow][j])));
            end
        end
        acc = 0;
        for (i = 0; i < m; i++)
            acc += mul_q(cost_shadow[basis_shadow[i] % 32], tab_shadow[i][cols]);
        rec.kind = KIND_STATUS;
        rec.status = status[2:0];
        rec.objective = sat_q(acc);
        rec.row = '0;
        rec.column = '0;
        rec.value = '0;
        rec.last = 1'b0;
        pending_records.push_back(rec);
        for (i = 0; i < m; i++)
        begin
            rec.kind = KIND_BASIS;
            rec.status = '0;
            rec.objective = '0;
            rec.row = i[2:0];
            rec.column = basis_shadow[i][4:0];
            rec.value = tab_shadow[i][cols];
            rec.last = (i == m - 1);
            pending_records.push_back(rec);
        end
        status_hist[status]++;
        solves_done++;
    endtask

    // ---------------------------------------------------------------- drivers

    // one input item, with random idle cycles ahead of it unless calm is set
    task automatic send_item(logic [1:0] action, logic [2:0] row, logic [5:0] col,
                             logic [31:0] val);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = action;
        s_tdata = {7'd0, val, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        if (action == ACT_LOAD_TAB && col <= 6'd32)
        begin
            tab_shadow[row][col] = int'(val);
            items_sent++;
        end
        else if (action == ACT_LOAD_COST && col < 6'd32)
        begin
            cost_shadow[col] = int'(val);
            items_sent++;
        end
        else if (action == ACT_SOLVE)
        begin
            predict_solve();
            items_sent++;
        end
    endtask

    // stop sending and let every outstanding record drain
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_NUM_ROWS:  rows_reg = data[3:0];
            REG_NUM_VARS:  vars_reg = data[3:0];
            REG_THRESHOLD: thresh_reg = data;
            REG_MAX_PIV:   maxpiv_reg = data;
            default:       thresh_reg = thresh_reg;
        endcase
    endtask

    task automatic set_config(logic [3:0] rows, logic [3:0] vars, logic [15:0] thresh,
                              logic [15:0] maxpiv);
        drain_results();
        write_reg(REG_NUM_ROWS, {12'd0, rows});
        write_reg(REG_NUM_VARS, {12'd0, vars});
        write_reg(REG_THRESHOLD, thresh);
        write_reg(REG_MAX_PIV, maxpiv);
    endtask

    // mostly small whole numbers and fractions, sometimes raw bits
    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0:       return $urandom;
            6, 7:    return 32'(int'($urandom_range(131071)) - ONE_Q);
            8:       return 32'd0;
            9:       return ONE_Q;
            default: return 32'((int'($urandom_range(8)) - 4) * ONE_Q);
        endcase
    endfunction

    // items that the solver must ignore
    task automatic send_noise();
        case ($urandom_range(2))
            0: send_item(2'd3, $urandom, $urandom, $urandom);
            1: send_item(ACT_LOAD_TAB, $urandom, $urandom_range(33, 63), $urandom);
            default: send_item(ACT_LOAD_COST, $urandom, $urandom_range(32, 63), $urandom);
        endcase
    endtask

    // fills every entry the next solve reads, with some stray items between
    task automatic load_problem();
        int m, n, cols, i, j;
        logic [31:0] v;
        m = used_count(rows_reg, 8);
        n = used_count(vars_reg, 8);
        cols = 2 * n + 2 * m;
        for (i = 0; i < m; i++)
            for (j = 0; j <= cols; j++)
            begin
                if (j == n + i)
                    case ($urandom_range(9))
                        0, 1, 2:    v = -ONE_Q;
                        3, 4:       v = rand_value();
                        default:    v = ONE_Q;
                    endcase
                else if (j == cols)
                    v = ($urandom_range(9) < 8) ? 32'($urandom_range(10) * ONE_Q) : rand_value();
                else
                    v = rand_value();
                send_item(ACT_LOAD_TAB, i[2:0], j[5:0], v);
                if ($urandom_range(99) < 8)
                    send_noise();
            end
        for (j = 0; j < cols; j++)
            send_item(ACT_LOAD_COST, 3'($urandom), j[5:0], rand_value());
    endtask

    // ---------------------------------------------------------------- checker

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = calm || ($urandom_range(99) >= 32);
        end
    end

    initial
    begin
        solve_record_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                records_seen++;
                if (pending_records.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected record: tuser %0d tdata %h", m_tuser, m_tdata);
                end
                else
                begin
                    want = pending_records.pop_front();
                    if (m_tuser[0] !== want.kind || m_tdata[2:0] !== want.status ||
                        m_tdata[34:3] !== want.objective || m_tdata[37:35] !== want.row ||
                        m_tdata[42:38] !== want.column || m_tdata[74:43] !== want.value ||
                        m_tdata[79:75] !== 5'd0 || m_tlast !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"record mismatch: kind %0d/%0d status %0d/%0d ",
                                      "obj %h/%h row %0d/%0d col %0d/%0d val %h/%h ",
                                      "last %0d/%0d (expected/actual)"},
                                     want.kind, m_tuser[0], want.status, m_tdata[2:0],
                                     want.objective, m_tdata[34:3], want.row, m_tdata[37:35],
                                     want.column, m_tdata[42:38], want.value, m_tdata[74:43],
                                     want.last, m_tlast);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // costs all zero: nothing prices in; extreme entry values in the tableau
    task automatic test_no_entering();
        set_config(4'd1, 4'd1, 16'd0, 16'd65535);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd0, 32'h80000000);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd1, ONE_Q);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd2, 32'h7fffffff);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd3, 32'hffffffff);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd4, 32'h7fffffff);
        for (int j = 0; j < 4; j++)
            send_item(ACT_LOAD_COST, 3'd7, j[5:0], 32'd0);
        send_item(ACT_SOLVE, 3'd7, 6'd63, 32'hffffffff);
    endtask

    // artificial start basis with nonzero then zero rhs
    task automatic test_artificial_basis();
        send_item(ACT_LOAD_TAB, 3'd0, 6'd1, -ONE_Q);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd4, 5 * ONE_Q);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd4, 32'd0);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
    endtask

    // entering column has no positive entry
    task automatic test_unbounded();
        send_item(ACT_LOAD_TAB, 3'd0, 6'd0, -ONE_Q);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd1, ONE_Q);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd4, 3 * ONE_Q);
        send_item(ACT_LOAD_COST, 3'd0, 6'd0, ONE_Q);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
    endtask

    // pivot limit of zero stops before any pivot, then one pivot allowed
    task automatic test_pivot_limit();
        set_config(4'd1, 4'd1, 16'd66, 16'd0);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd0, 2 * ONE_Q);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
        set_config(4'd1, 4'd1, 16'd66, 16'd1);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
    endtask

    // zero counts act as one; stray actions and indexes change nothing
    task automatic test_ignored_items();
        set_config(4'd0, 4'd0, 16'd0, 16'd4);
        send_item(2'd3, 3'd5, 6'd2, 32'h12345678);
        send_item(ACT_LOAD_TAB, 3'd0, 6'd33, 32'h55555555);
        send_item(ACT_LOAD_TAB, 3'd7, 6'd63, 32'haaaaaaaa);
        send_item(ACT_LOAD_COST, 3'd0, 6'd32, 32'h55555555);
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
    endtask

    // counts above the maximum saturate to the full tableau
    task automatic test_full_size();
        set_config(4'd15, 4'd15, 16'd65535, 16'd3);
        load_problem();
        send_item(ACT_SOLVE, 3'd0, 6'd0, 32'd0);
    endtask

    task automatic test_random_problems();
        int k;
        logic [15:0] thr, piv;
        k = 0;
        while (items_sent < 450)
        begin
            case ($urandom_range(3))
                0:       thr = 16'd0;
                1:       thr = 16'd65535;
                2:       thr = 16'd66;
                default: thr = $urandom;
            endcase
            piv = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            set_config($urandom_range(9) == 0 ? 4'($urandom) : 4'($urandom_range(1, 3)),
                       $urandom_range(9) == 0 ? 4'($urandom_range(4, 8)) :
                                                4'($urandom_range(1, 3)),
                       thr, piv);
            calm = (k >= 3 && k < 6);
            load_problem();
            send_item(ACT_SOLVE, $urandom, $urandom, $urandom);
            // resolve the pivoted tableau now and then
            if ($urandom_range(3) == 0)
                send_item(ACT_SOLVE, $urandom, $urandom, $urandom);
            calm = 1'b0;
            k++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        calm = 1'b0;
        mismatch_count = 0;
        items_sent = 0;
        records_seen = 0;
        solves_done = 0;
        for (int s = 0; s < 5; s++)
            status_hist[s] = 0;
        rows_reg = NUM_ROWS_RST;
        vars_reg = NUM_VARS_RST;
        thresh_reg = THRESHOLD_RST;
        maxpiv_reg = MAX_PIV_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_entering();
        test_artificial_basis();
        test_unbounded();
        test_pivot_limit();
        test_ignored_items();
        test_full_size();
        test_random_problems();

        drain_results();
        repeat (50) @(posedge clk);
        $display("%0d items, %0d solves, %0d records checked", items_sent, solves_done,
                 records_seen);
        $display("status counts: optimal %0d art-zero %0d infeasible %0d unbounded %0d limit %0d",
                 status_hist[0], status_hist[1], status_hist[2], status_hist[3],
                 status_hist[4]);
        if (mismatch_count == 0 && pending_records.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== tableau_simplex_solver.f =====
hdl/tss_pkg.sv
hdl/tss_div.sv
hdl/tableau_simplex_solver.sv
bench/tableau_simplex_solver_tb.sv
